>>> hw/rtl/bcr_pkg.sv
// Package for the bouncing circle renderer: field widths, register map,
// mode codes, reset values and the structs passed between modules.
// No dependencies.
package bcr_pkg;

	// Geometry and state widths
	localparam int NUM_CIRCLES_DEF = 3;
	localparam int CENTRE_W        = 10;
	localparam int VEL_W           = 4;
	localparam int SIZE_W          = 8;
	localparam int RADIUS_W        = 6;
	localparam int PIX_W           = 8;
	localparam int INDEX_W         = 2;
	localparam int NUM_RADII       = 3;

	// APB register map (byte address = 4 * index)
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_RADIUS_FIRST  = 3'd2;
	localparam logic [2:0] REG_RADIUS_SECOND = 3'd3;
	localparam logic [2:0] REG_RADIUS_THIRD  = 3'd4;

	// Register reset values
	localparam logic [SIZE_W-1:0]   WIDTH_RST  = 8'd80;
	localparam logic [SIZE_W-1:0]   HEIGHT_RST = 8'd26;
	localparam logic [RADIUS_W-1:0] RADIUS_RST [NUM_RADII] = '{6'd4, 6'd2, 6'd6};

	// Input item modes
	localparam logic MODE_QUERY = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// Circle state after reset
	localparam logic signed [CENTRE_W-1:0] CX_RST = 10'sd40;
	localparam logic signed [CENTRE_W-1:0] CY_RST = 10'sd13;
	localparam logic signed [VEL_W-1:0] VX_RST [NUM_RADII] = '{4'sd1, -4'sd1, -4'sd3};
	localparam logic signed [VEL_W-1:0] VY_RST [NUM_RADII] = '{4'sd1, -4'sd1, -4'sd1};

	// Configuration as seen by the circle lanes
	typedef struct packed {
		logic [SIZE_W-1:0]                  screen_width;
		logic [SIZE_W-1:0]                  screen_height;
		logic [NUM_RADII-1:0][RADIUS_W-1:0] radius;
	} bcr_cfg_t;

	// Per-lane request: move strobe and the queried pixel
	typedef struct packed {
		logic             tick;
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} bcr_req_t;

	// One axis after the edge checks
	typedef struct packed {
		logic signed [CENTRE_W-1:0] pos;
		logic signed [VEL_W-1:0]    vel;
	} bcr_axis_t;

endpackage

>>> hw/rtl/bcr_if.sv
// Valid/ready channel interfaces for the renderer's input and result beats.
// Depends on bcr_pkg.
interface bcr_in_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [bcr_pkg::PIX_W-1:0]    pixel_x;
	logic [bcr_pkg::PIX_W-1:0]    pixel_y;

	modport source (output valid, output mode, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input mode, input pixel_x, input pixel_y, output ready);
endinterface

interface bcr_out_if;
	logic                         valid;
	logic                         ready;
	logic                         covered;
	logic [bcr_pkg::INDEX_W-1:0]  circle_index;

	modport source (output valid, output covered, output circle_index, input ready);
	modport sink   (input valid, input covered, input circle_index, output ready);
endinterface

>>> hw/rtl/bcr_cfg.sv
// APB configuration registers: playfield size and the three radii.
// Depends on bcr_pkg.
module bcr_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bcr_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bcr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bcr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output bcr_pkg::bcr_cfg_t               cfg
);

	logic [bcr_pkg::SIZE_W-1:0]   width_q;
	logic [bcr_pkg::SIZE_W-1:0]   height_q;
	logic [bcr_pkg::RADIUS_W-1:0] radius_q [bcr_pkg::NUM_RADII];
	logic                         wr_en;
	logic [2:0]                   reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bcr_pkg::WIDTH_RST;
			height_q <= bcr_pkg::HEIGHT_RST;
			for (int i = 0; i < bcr_pkg::NUM_RADII; i++) begin
				radius_q[i] <= bcr_pkg::RADIUS_RST[i];
			end
		end else if (wr_en) begin
			unique case (reg_idx)
				bcr_pkg::REG_SCREEN_WIDTH:  width_q     <= pwdata[bcr_pkg::SIZE_W-1:0];
				bcr_pkg::REG_SCREEN_HEIGHT: height_q    <= pwdata[bcr_pkg::SIZE_W-1:0];
				bcr_pkg::REG_RADIUS_FIRST:  radius_q[0] <= pwdata[bcr_pkg::RADIUS_W-1:0];
				bcr_pkg::REG_RADIUS_SECOND: radius_q[1] <= pwdata[bcr_pkg::RADIUS_W-1:0];
				bcr_pkg::REG_RADIUS_THIRD:  radius_q[2] <= pwdata[bcr_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			bcr_pkg::REG_SCREEN_WIDTH:  prdata = 32'(width_q);
			bcr_pkg::REG_SCREEN_HEIGHT: prdata = 32'(height_q);
			bcr_pkg::REG_RADIUS_FIRST:  prdata = 32'(radius_q[0]);
			bcr_pkg::REG_RADIUS_SECOND: prdata = 32'(radius_q[1]);
			bcr_pkg::REG_RADIUS_THIRD:  prdata = 32'(radius_q[2]);
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		cfg.screen_width  = width_q;
		cfg.screen_height = height_q;
		for (int i = 0; i < bcr_pkg::NUM_RADII; i++) begin
			cfg.radius[i] = radius_q[i];
		end
	end

endmodule

>>> hw/rtl/bcr_circle.sv
// One circle lane: centre and velocity registers, bounce/move on a tick and
// the strict containment test for the queried pixel. Depends on bcr_pkg.
module bcr_circle #(
	parameter int LANE = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bcr_pkg::bcr_req_t               req,
	input  logic [bcr_pkg::SIZE_W-1:0]      screen_width,
	input  logic [bcr_pkg::SIZE_W-1:0]      screen_height,
	input  logic [bcr_pkg::RADIUS_W-1:0]    radius,
	output logic                            hit
);

	localparam int RST_SEL = LANE % bcr_pkg::NUM_RADII;

	logic signed [bcr_pkg::CENTRE_W-1:0] cx_q, cy_q;
	logic signed [bcr_pkg::VEL_W-1:0]    vx_q, vy_q;
	bcr_pkg::bcr_axis_t                  ax_x, ax_y;
	logic signed [bcr_pkg::CENTRE_W:0]   dx, dy;
	logic signed [2*bcr_pkg::CENTRE_W+1:0] dx2, dy2;
	logic [2*bcr_pkg::CENTRE_W+2:0]      dist2;
	logic [2*bcr_pkg::RADIUS_W-1:0]      r2;

	// Low edge check, then high edge check; each that fires flips the velocity
	function automatic bcr_pkg::bcr_axis_t bounce(
		input logic signed [bcr_pkg::CENTRE_W-1:0] pos,
		input logic signed [bcr_pkg::VEL_W-1:0]    vel,
		input logic [bcr_pkg::RADIUS_W-1:0]        r,
		input logic [bcr_pkg::SIZE_W-1:0]          size
	);
		logic signed [11:0] p, re, se;
		logic signed [bcr_pkg::VEL_W-1:0] v;
		bcr_pkg::bcr_axis_t res;
		p  = 12'(pos);
		re = $signed({6'b0, r});
		se = $signed({4'b0, size});
		v  = vel;
		if (p - re < 0) begin
			v = -v;
			p = re;
		end
		if (p + re > se) begin
			v = -v;
			p = se - re;
		end
		res.pos = p[bcr_pkg::CENTRE_W-1:0] + bcr_pkg::CENTRE_W'(v);
		res.vel = v;
		return res;
	endfunction

	assign ax_y = bounce(cy_q, vy_q, radius, screen_height);
	assign ax_x = bounce(cx_q, vx_q, radius, screen_width);

	// Circle state, moved on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= bcr_pkg::CX_RST;
			cy_q <= bcr_pkg::CY_RST;
			vx_q <= bcr_pkg::VX_RST[RST_SEL];
			vy_q <= bcr_pkg::VY_RST[RST_SEL];
		end else if (req.tick) begin
			cx_q <= ax_x.pos;
			cy_q <= ax_y.pos;
			vx_q <= ax_x.vel;
			vy_q <= ax_y.vel;
		end
	end

	// Squared distance against squared radius, strict
	assign dx    = $signed({3'b0, req.pixel_x}) - $signed({cx_q[bcr_pkg::CENTRE_W-1], cx_q});
	assign dy    = $signed({3'b0, req.pixel_y}) - $signed({cy_q[bcr_pkg::CENTRE_W-1], cy_q});
	assign dx2   = dx * dx;
	assign dy2   = dy * dy;
	assign dist2 = {1'b0, dx2} + {1'b0, dy2};
	assign r2    = radius * radius;
	assign hit   = dist2 < (2*bcr_pkg::CENTRE_W+3)'(r2);

endmodule

>>> hw/rtl/bouncing_circle_renderer_top.sv
// Bouncing circle renderer top level: input register, circle lanes, result register.
// A query passes the input register and then the result register; ticks give no result.
// Throughput: one item per cycle while the result side takes every beat; the limit
// is the single result register, which frees when its beat is taken.
// Reset (arst_n, asynchronous): registers to defaults, circles to their start state.
// Depends on bcr_pkg, bcr_if, bcr_cfg and bcr_circle.
module bouncing_circle_renderer_top #(
	parameter int NUM_CIRCLES = bcr_pkg::NUM_CIRCLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bcr_in_if.sink                          in_ch,
	bcr_out_if.source                       out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bcr_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bcr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bcr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	bcr_pkg::bcr_cfg_t           cfg;
	bcr_pkg::bcr_req_t           req;
	logic                        valid_s1, mode_s1;
	logic [bcr_pkg::PIX_W-1:0]   pixel_x_s1, pixel_y_s1;
	logic                        valid_s2, covered_s2;
	logic [bcr_pkg::INDEX_W-1:0] index_s2;
	logic                        out_free, s1_go, in_beat, load_s2;
	logic [NUM_CIRCLES-1:0]      hits;
	logic                        any_hit;
	logic [bcr_pkg::INDEX_W-1:0] hit_idx;

	bcr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: a tick always leaves stage 1, a query needs a free result slot
	assign out_free    = !valid_s2 || out_ch.ready;
	assign s1_go       = valid_s1 && (mode_s1 == bcr_pkg::MODE_TICK || out_free);
	assign in_ch.ready = !valid_s1 || s1_go;
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign load_s2     = valid_s1 && mode_s1 == bcr_pkg::MODE_QUERY && out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			mode_s1    <= in_ch.mode;
			pixel_x_s1 <= in_ch.pixel_x;
			pixel_y_s1 <= in_ch.pixel_y;
		end
	end

	assign req.tick    = valid_s1 && mode_s1 == bcr_pkg::MODE_TICK;
	assign req.pixel_x = pixel_x_s1;
	assign req.pixel_y = pixel_y_s1;

	// Circle lanes
	for (genvar i = 0; i < NUM_CIRCLES; i++) begin : g_lane
		bcr_circle #(.LANE(i)) u_circle (
			.clk           (clk),
			.arst_n        (arst_n),
			.req           (req),
			.screen_width  (cfg.screen_width),
			.screen_height (cfg.screen_height),
			.radius        (cfg.radius[i % bcr_pkg::NUM_RADII]),
			.hit           (hits[i])
		);
	end

	// Highest-numbered covering circle wins
	always_comb begin
		any_hit = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < NUM_CIRCLES; i++) begin
			if (hits[i]) begin
				any_hit = 1'b1;
				hit_idx = bcr_pkg::INDEX_W'(i);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			covered_s2 <= any_hit;
			index_s2   <= hit_idx;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.covered      = covered_s2;
	assign out_ch.circle_index = index_s2;

	// Checks
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.covered |-> out_ch.circle_index == '0)
		else $error("circle_index set on an uncovered result");

	a_tick_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && mode_s1 == bcr_pkg::MODE_TICK |=> !$rose(valid_s2))
		else $error("tick produced a result beat");

	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.ready |-> in_ch.ready)
		else $error("input stalled while results drain");

	a_query_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && mode_s1 == bcr_pkg::MODE_QUERY && valid_s2 && !out_ch.ready
		|=> valid_s1 && $stable(pixel_x_s1) && $stable(pixel_y_s1))
		else $error("stalled query lost from stage 1");

endmodule

>>> verif/bouncing_circle_renderer_top_tb.sv
// Testbench for bouncing_circle_renderer_top: directed and random ticks and pixel
// queries, checked beat by beat against a predictor of the circle state.
// Depends on bcr_pkg, bcr_if and the renderer RTL.
module bouncing_circle_renderer_top_tb;

	localparam int N_CIRCLES   = bcr_pkg::NUM_CIRCLES_DEF;
	localparam int STALL_LIMIT = 2000;
	// indexes past the end of the register map: writes there are dropped
	localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
	localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic                        covered;
		logic [bcr_pkg::INDEX_W-1:0] idx;
	} hit_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [bcr_pkg::APB_ADDR_W-1:0] paddr;
	logic [bcr_pkg::APB_DATA_W-1:0] pwdata;
	logic [bcr_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	bcr_in_if  in_ch ();
	bcr_out_if out_ch ();

	bouncing_circle_renderer_top #(.NUM_CIRCLES(N_CIRCLES)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Predicted circle state and register copies
	logic signed [bcr_pkg::CENTRE_W-1:0] pos_x [N_CIRCLES];
	logic signed [bcr_pkg::CENTRE_W-1:0] pos_y [N_CIRCLES];
	logic signed [bcr_pkg::VEL_W-1:0]    spd_x [N_CIRCLES];
	logic signed [bcr_pkg::VEL_W-1:0]    spd_y [N_CIRCLES];
	logic [bcr_pkg::SIZE_W-1:0]          field_w;
	logic [bcr_pkg::SIZE_W-1:0]          field_h;
	logic [bcr_pkg::RADIUS_W-1:0]        rad [bcr_pkg::NUM_RADII];

	hit_t        hits_due [$];
	int          errors;
	int          n_queries;
	int          n_ticks;
	int          n_beats;
	int          n_settings;
	int unsigned quiet;
	bit          idle_in;
	bit          stall_out;

	// Edge check on one axis: low edge first, then high edge
	task automatic bounce(inout logic signed [bcr_pkg::CENTRE_W-1:0] pos,
			inout logic signed [bcr_pkg::VEL_W-1:0] vel, input int r, input int size);
		if (int'(pos) - r < 0) begin
			vel = -vel;
			pos = bcr_pkg::CENTRE_W'(r);
		end
		if (int'(pos) + r > size) begin
			vel = -vel;
			pos = bcr_pkg::CENTRE_W'(size - r);
		end
	endtask

	task automatic advance_circles();
		int r;
		for (int i = 0; i < N_CIRCLES; i++) begin
			r = int'(rad[i % bcr_pkg::NUM_RADII]);
			bounce(pos_y[i], spd_y[i], r, int'(field_h));
			bounce(pos_x[i], spd_x[i], r, int'(field_w));
			pos_y[i] = pos_y[i] + spd_y[i];
			pos_x[i] = pos_x[i] + spd_x[i];
		end
	endtask

	// Strict containment; the last circle that contains the pixel wins
	function automatic hit_t hit_test(logic [bcr_pkg::PIX_W-1:0] px,
			logic [bcr_pkg::PIX_W-1:0] py);
		hit_t h;
		int   dx;
		int   dy;
		int   r;
		h = '0;
		for (int i = 0; i < N_CIRCLES; i++) begin
			r  = int'(rad[i % bcr_pkg::NUM_RADII]);
			dx = int'(px) - int'(pos_x[i]);
			dy = int'(py) - int'(pos_y[i]);
			if (dx * dx + dy * dy < r * r) begin
				h.covered = 1'b1;
				h.idx     = bcr_pkg::INDEX_W'(i);
			end
		end
		return h;
	endfunction

	// Pixel coordinate a little inside or outside a circle edge
	function automatic logic [bcr_pkg::PIX_W-1:0] aim(int centre, int r);
		int v;
		v = centre + int'($urandom_range(2 * r + 2, 0)) - (r + 1);
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return bcr_pkg::PIX_W'(v);
	endfunction

	// One input beat, with random idle cycles ahead of it
	task automatic send_item(logic mode, logic [bcr_pkg::PIX_W-1:0] px,
			logic [bcr_pkg::PIX_W-1:0] py);
		while (idle_in && $urandom_range(99) < 27) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.mode    <= mode;
		in_ch.pixel_x <= px;
		in_ch.pixel_y <= py;
		do @(posedge clk); while (!in_ch.ready);
		if (mode == bcr_pkg::MODE_TICK) begin
			advance_circles();
			n_ticks++;
		end else begin
			hits_due.push_back(hit_test(px, py));
			n_queries++;
		end
	endtask

	// Hold the sender until every outstanding result is back
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (hits_due.size() != 0);
	endtask

	// Ticks leave no result, so allow the pipeline to empty as well
	task automatic settle();
		drain();
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_xfer(logic wr, logic [2:0] idx, logic [bcr_pkg::APB_DATA_W-1:0] wdata,
			output logic [bcr_pkg::APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Register write, mirrored into the predictor, then read back where mapped
	task automatic write_reg(logic [2:0] idx, logic [bcr_pkg::APB_DATA_W-1:0] val);
		logic [bcr_pkg::APB_DATA_W-1:0] rd;
		logic [bcr_pkg::APB_DATA_W-1:0] want;
		bit                             mapped;
		apb_xfer(1'b1, idx, val, rd);
		mapped = 1'b1;
		case (idx)
			bcr_pkg::REG_SCREEN_WIDTH: begin
				field_w = val[bcr_pkg::SIZE_W-1:0];
				want    = bcr_pkg::APB_DATA_W'(field_w);
			end
			bcr_pkg::REG_SCREEN_HEIGHT: begin
				field_h = val[bcr_pkg::SIZE_W-1:0];
				want    = bcr_pkg::APB_DATA_W'(field_h);
			end
			bcr_pkg::REG_RADIUS_FIRST: begin
				rad[0] = val[bcr_pkg::RADIUS_W-1:0];
				want   = bcr_pkg::APB_DATA_W'(rad[0]);
			end
			bcr_pkg::REG_RADIUS_SECOND: begin
				rad[1] = val[bcr_pkg::RADIUS_W-1:0];
				want   = bcr_pkg::APB_DATA_W'(rad[1]);
			end
			bcr_pkg::REG_RADIUS_THIRD: begin
				rad[2] = val[bcr_pkg::RADIUS_W-1:0];
				want   = bcr_pkg::APB_DATA_W'(rad[2]);
			end
			default: begin
				mapped = 1'b0;
				want   = '0;
			end
		endcase
		if (mapped) begin
			apb_xfer(1'b0, idx, '0, rd);
			if (rd !== want) begin
				$error("prdata: expected %0d, got %0d", want, rd);
				errors++;
			end
		end
	endtask

	task automatic apply_setting(int w, int h, int r0, int r1, int r2);
		settle();
		write_reg(bcr_pkg::REG_SCREEN_WIDTH, bcr_pkg::APB_DATA_W'(w));
		write_reg(bcr_pkg::REG_SCREEN_HEIGHT, bcr_pkg::APB_DATA_W'(h));
		write_reg(bcr_pkg::REG_RADIUS_FIRST, bcr_pkg::APB_DATA_W'(r0));
		write_reg(bcr_pkg::REG_RADIUS_SECOND, bcr_pkg::APB_DATA_W'(r1));
		write_reg(bcr_pkg::REG_RADIUS_THIRD, bcr_pkg::APB_DATA_W'(r2));
		n_settings++;
	endtask

	// Reset values: coincident circles, boundaries of the first and third radius, far corners
	task automatic test_reset_state();
		send_item(bcr_pkg::MODE_QUERY, 8'd40, 8'd13);
		send_item(bcr_pkg::MODE_QUERY, 8'd45, 8'd13);
		send_item(bcr_pkg::MODE_QUERY, 8'd46, 8'd13);
		send_item(bcr_pkg::MODE_QUERY, 8'd40, 8'd9);
		send_item(bcr_pkg::MODE_QUERY, 8'd0, 8'd0);
		send_item(bcr_pkg::MODE_QUERY, 8'd255, 8'd255);
		send_item(bcr_pkg::MODE_TICK, 8'd255, 8'd0);
		send_item(bcr_pkg::MODE_TICK, 8'd0, 8'd255);
		send_item(bcr_pkg::MODE_QUERY, 8'd41, 8'd14);
	endtask

	// Register map: masking of wide data, dropped writes, higher circles winning
	task automatic test_register_map();
		settle();
		write_reg(bcr_pkg::REG_SCREEN_WIDTH, 32'hABCD_EF00 | 32'd200);
		write_reg(bcr_pkg::REG_SCREEN_HEIGHT, 32'hFFFF_FF00 | 32'd100);
		write_reg(bcr_pkg::REG_RADIUS_FIRST, 32'hFFFF_FFC0 | 32'd10);
		write_reg(bcr_pkg::REG_RADIUS_SECOND, 32'd3);
		write_reg(bcr_pkg::REG_RADIUS_THIRD, 32'd0);
		write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
		write_reg(REG_UNMAPPED_HI, 32'h0000_0001);
		n_settings++;
		send_item(bcr_pkg::MODE_QUERY, bcr_pkg::PIX_W'(pos_x[1]), bcr_pkg::PIX_W'(pos_y[1]));
		send_item(bcr_pkg::MODE_QUERY, bcr_pkg::PIX_W'(int'(pos_x[0]) + 6),
				bcr_pkg::PIX_W'(pos_y[0]));
		send_item(bcr_pkg::MODE_QUERY, bcr_pkg::PIX_W'(pos_x[2]),
				bcr_pkg::PIX_W'(int'(pos_y[2]) + 9));
	endtask

	// Playfield smaller than a diameter, then a playfield of size zero
	task automatic test_degenerate_field();
		apply_setting(1, 1, 63, 0, 1);
		send_item(bcr_pkg::MODE_TICK, 8'd0, 8'd0);
		send_item(bcr_pkg::MODE_QUERY, 8'd0, 8'd0);
		send_item(bcr_pkg::MODE_TICK, 8'd0, 8'd0);
		send_item(bcr_pkg::MODE_QUERY, 8'd1, 8'd1);
		send_item(bcr_pkg::MODE_QUERY, 8'd255, 8'd0);
		apply_setting(0, 0, 5, 63, 0);
		send_item(bcr_pkg::MODE_TICK, 8'd0, 8'd0);
		send_item(bcr_pkg::MODE_QUERY, 8'd0, 8'd0);
		send_item(bcr_pkg::MODE_TICK, 8'd0, 8'd0);
		send_item(bcr_pkg::MODE_QUERY, 8'd128, 8'd128);
	endtask

	// Random phases under several settings; one phase runs with no idling
	task automatic test_random_phases(int per_phase);
		int c;
		int r;
		for (int p = 0; p < 6; p++) begin
			idle_in   = (p != 3);
			stall_out = (p != 3);
			case (p)
				0: apply_setting(255, 255, 63, 63, 63);
				1: apply_setting(1, 1, 0, 63, 17);
				4: apply_setting(0, 255, 63, 0, 31);
				5: apply_setting(int'(bcr_pkg::WIDTH_RST), int'(bcr_pkg::HEIGHT_RST),
						int'(bcr_pkg::RADIUS_RST[0]), int'(bcr_pkg::RADIUS_RST[1]),
						int'(bcr_pkg::RADIUS_RST[2]));
				default: apply_setting($urandom_range(255, 1), $urandom_range(255, 1),
						$urandom_range(63), $urandom_range(63), $urandom_range(63));
			endcase
			for (int k = 0; k < per_phase; k++) begin
				if (k == per_phase / 2)
					drain();
				if ($urandom_range(5) == 0) begin
					send_item(bcr_pkg::MODE_TICK, bcr_pkg::PIX_W'($urandom),
							bcr_pkg::PIX_W'($urandom));
				end else if ($urandom_range(9) < 6) begin
					c = $urandom_range(N_CIRCLES - 1);
					r = int'(rad[c % bcr_pkg::NUM_RADII]);
					send_item(bcr_pkg::MODE_QUERY, aim(int'(pos_x[c]), r),
							aim(int'(pos_y[c]), r));
				end else begin
					send_item(bcr_pkg::MODE_QUERY, bcr_pkg::PIX_W'($urandom),
							bcr_pkg::PIX_W'($urandom));
				end
			end
		end
		idle_in   = 1'b1;
		stall_out = 1'b1;
	endtask

	// Result side: random stalls, each beat compared with the oldest prediction
	initial begin
		hit_t exp_hit;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				n_beats++;
				if (hits_due.size() == 0) begin
					$error("unexpected result beat: covered %0d circle_index %0d",
							out_ch.covered, out_ch.circle_index);
					errors++;
				end else begin
					exp_hit = hits_due.pop_front();
					if (out_ch.covered !== exp_hit.covered) begin
						$error("covered: expected %0d, got %0d",
								exp_hit.covered, out_ch.covered);
						errors++;
					end
					if (out_ch.circle_index !== exp_hit.idx) begin
						$error("circle_index: expected %0d, got %0d",
								exp_hit.idx, out_ch.circle_index);
						errors++;
					end
				end
			end
			out_ch.ready <= arst_n && !(stall_out && $urandom_range(99) < 27);
		end
	end

	// Watchdog on cycles with no beat on either channel and no register access
	initial begin
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		in_ch.valid   <= 1'b0;
		in_ch.mode    <= bcr_pkg::MODE_QUERY;
		in_ch.pixel_x <= '0;
		in_ch.pixel_y <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		errors     = 0;
		n_queries  = 0;
		n_ticks    = 0;
		n_beats    = 0;
		n_settings = 1;
		idle_in    = 1'b1;
		stall_out  = 1'b1;
		field_w    = bcr_pkg::WIDTH_RST;
		field_h    = bcr_pkg::HEIGHT_RST;
		for (int i = 0; i < bcr_pkg::NUM_RADII; i++)
			rad[i] = bcr_pkg::RADIUS_RST[i];
		for (int i = 0; i < N_CIRCLES; i++) begin
			pos_x[i] = bcr_pkg::CX_RST;
			pos_y[i] = bcr_pkg::CY_RST;
			spd_x[i] = bcr_pkg::VX_RST[i % bcr_pkg::NUM_RADII];
			spd_y[i] = bcr_pkg::VY_RST[i % bcr_pkg::NUM_RADII];
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_register_map();
		test_degenerate_field();
		test_random_phases(160);

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d queries and %0d ticks, checked %0d result beats under %0d settings,",
				n_queries, n_ticks, n_beats, n_settings);
		$display("among them empty, one-cell and full-size playfields and radii of 0 and 63.");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
